// ===== design/sorted_priority_queue_assert.svh =====
// Assertion macros used by the priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Types and codes shared by the priority queue controller, datapath and top level.
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [3:0]         entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_FULL,
    CMD_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    logic      load;
    cmd_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic op_remove;
    logic full;
    logic empty;
  } dp_status_t;

endpackage

// ===== design/spq_controller.sv =====
// Controller state machine that sequences one queue operation at a time.
module spq_controller import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t dp_status,
  output logic       busy,
  output dp_cmd_t    dp_cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_EXEC;
            busy_r  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    dp_cmd.load = 1'b0;
    dp_cmd.kind = CMD_NONE;
    unique case (state_r)
      ST_IDLE: dp_cmd.load = start;
      ST_EXEC: begin
        // The full and empty checks settle what the captured item does.
        priority if (dp_status.op_remove && dp_status.empty) begin
          dp_cmd.kind = CMD_EMPTY;
        end else if (dp_status.op_remove) begin
          dp_cmd.kind = CMD_REMOVE;
        end else if (dp_status.full) begin
          dp_cmd.kind = CMD_FULL;
        end else begin
          dp_cmd.kind = CMD_INSERT;
        end
      end
      default: dp_cmd.kind = CMD_NONE;
    endcase
  end

  assign busy = busy_r;

endmodule

// ===== design/spq_datapath.sv =====
// Datapath: a row of compare-and-shift cells holding the sorted entries.
module spq_datapath import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  dp_cmd_t    dp_cmd,
  output dp_status_t dp_status,
  output logic       out_valid,
  output out_item_t  out_item
);

  logic               op_r;
  logic signed [31:0] value_r;
  logic signed [31:0] entries_r [QUEUE_DEPTH];
  logic signed [31:0] ins_nxt   [QUEUE_DEPTH];
  logic signed [31:0] rem_nxt   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] lt;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               out_valid_r;
  out_item_t          out_item_r;

  // A cell is below the new value only if it is live and strictly smaller,
  // so the new value lands ahead of equal entries.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign lt[i] = (i < int'(count_r)) && (entries_r[i] < value_r);
    if (i == 0) begin : g_front
      assign ins_nxt[i] = lt[i] ? entries_r[i] : value_r;
    end else begin : g_rest
      assign ins_nxt[i] = lt[i] ? entries_r[i] : (lt[i-1] ? value_r : entries_r[i-1]);
    end
    if (i == QUEUE_DEPTH - 1) begin : g_back
      assign rem_nxt[i] = entries_r[i];
    end else begin : g_shift
      assign rem_nxt[i] = entries_r[i+1];
    end
  end

  always_comb begin
    unique case (dp_cmd.kind)
      CMD_INSERT: count_nxt = count_r + CW'(1);
      CMD_REMOVE: count_nxt = count_r - CW'(1);
      default:    count_nxt = count_r;
    endcase
  end

  assign dp_status.op_remove = (op_r == OP_REMOVE);
  assign dp_status.full      = (count_r == CW'(QUEUE_DEPTH));
  assign dp_status.empty     = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= (dp_cmd.kind != CMD_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op_r    <= in_item.op;
      value_r <= in_item.value;
    end
    unique case (dp_cmd.kind)
      CMD_INSERT: entries_r <= ins_nxt;
      CMD_REMOVE: entries_r <= rem_nxt;
      default:    ;
    endcase
    if (dp_cmd.kind != CMD_NONE) begin
      out_item_r.entry_count   <= 4'(count_nxt);
      out_item_r.removed_value <= (dp_cmd.kind == CMD_REMOVE) ? entries_r[0] : '0;
      unique case (dp_cmd.kind)
        CMD_FULL:  out_item_r.status <= STATUS_FULL;
        CMD_EMPTY: out_item_r.status <= STATUS_EMPTY;
        default:   out_item_r.status <= STATUS_DONE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller plus cell datapath.
//
// Bounded priority queue of signed 32-bit values kept in ascending order.
// Input: drive in_item (op and value) with start; the item is accepted at
// the rising edge where start is high and busy is low. op insert places the
// value ahead of any equal entries, op remove takes the smallest entry.
// Result: out_valid pulses for one cycle with out_item holding status
// (done, full or empty), the removed value (zero unless a remove succeeded)
// and the entry count after the operation. The receiver cannot stall; each
// result must be taken in the cycle it is shown.
// Sequencing: the accepting edge captures the item and enters the execute
// state, whose result is registered and then shown. busy is high for the one
// execute cycle, so a new item cannot be taken until the last one executes;
// that limit is set by the capture-then-execute sequence of the controller.
// The execute cycle updates every cell in parallel, each with one 32-bit
// compare against the captured value.
// Reset (rst_n low, synchronous) empties the queue and clears busy and
// out_valid; entry storage itself is not cleared.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  `include "sorted_priority_queue_assert.svh"

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  spq_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_status (dp_status),
    .busy      (busy),
    .dp_cmd    (dp_cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `SPQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")
  `SPQ_ASSERT_NXT(a_exec_result, clk, rst_n, busy, out_valid && !busy, "execute cycle gave no result")
  `SPQ_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy, "result shown while busy")
  `SPQ_ASSERT_IMP(a_full_count, clk, rst_n, out_valid && out_item.status == STATUS_FULL,
    out_item.entry_count == 4'(QUEUE_DEPTH), "full status with a short queue")

endmodule
